/* rtl/ctsu_pkg.sv */
// Shared types and constants of the cooperative task scheduler.
`timescale 1ns / 1ps

package ctsu_pkg;

	// Table size and the widths that follow from it.
	localparam int MAX_TASKS = 16;
	localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);

	// Fixed field widths.
	localparam int MODE_W = 3;
	localparam int TAG_W  = 8;
	localparam int TICK_W = 32;
	localparam int IDX_W  = 4;
	localparam int KIND_W = 2;

	// Input modes.
	localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DISPATCH = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ADD      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_DONE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RUN    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

	// One table entry.
	typedef struct packed {
		logic [TAG_W-1:0]  handler;
		logic [TICK_W-1:0] deadline;
		logic [TICK_W-1:0] period;
	} slot_t;

	// One pending result.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TAG_W-1:0]  handler;
		logic              last;
	} result_t;

endpackage

/* rtl/cooperative_task_scheduler_unit.sv */
// Top level of the cooperative task scheduler: sequencer, slot table and shared adder.
`timescale 1ns / 1ps

// Time-triggered cooperative scheduler. The block holds a 32-bit tick counter
// and a compacted table of up to MAX_TASKS slots (handler tag, absolute
// deadline, period); live slots are always 0 .. total-1. One item is taken at
// a time: in_ready is high only while the sequencer is idle. Tick, add, clear
// and unused modes decode and then emit their single result. Delete of a live
// slot shifts each later slot down before its result; a bad index is rejected.
// Dispatch goes through accept, decode, a read and compare per slot examined,
// an emit and update per run result, a shift of the later slots when a one-shot
// task retires, and a final check and done result. The pace is set by the slot
// table (one read port and one write port, read data registered) and by the
// one 33-bit adder that does the deadline compare, the period advance and the
// tick increment in turn. Each result waits in an output register until taken;
// the sequencer stalls only while that register is still full.
module cooperative_task_scheduler_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ctsu_pkg::MODE_W-1:0]   mode,
	input  logic [ctsu_pkg::TAG_W-1:0]    handler_tag,
	input  logic [ctsu_pkg::TICK_W-1:0]   delay_ticks,
	input  logic [ctsu_pkg::TICK_W-1:0]   period_ticks,
	input  logic [ctsu_pkg::IDX_W-1:0]    slot_index,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ctsu_pkg::KIND_W-1:0]   kind,
	output logic [ctsu_pkg::TAG_W-1:0]    run_handler,
	output logic                          last
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_CMP,
		ST_EMIT,
		ST_UPDATE,
		ST_SHIFT_RD,
		ST_SHIFT_WR
	} state_t;

	typedef enum logic [1:0] {
		OP_INC,
		OP_GE,
		OP_ADV
	} alu_op_t;

	state_t                            state_q;
	logic [ctsu_pkg::MODE_W-1:0]       mode_q;
	logic [ctsu_pkg::TAG_W-1:0]        tag_q;
	logic [ctsu_pkg::TICK_W-1:0]       delay_q;
	logic [ctsu_pkg::TICK_W-1:0]       period_q;
	logic [ctsu_pkg::IDX_W-1:0]        idx_q;
	logic [ctsu_pkg::TICK_W-1:0]       tick_q;
	logic [ctsu_pkg::CNT_W-1:0]        total_q;
	logic [ctsu_pkg::CNT_W-1:0]        walk_q;    // slot under examination
	logic [ctsu_pkg::CNT_W-1:0]        shift_q;   // compaction destination
	ctsu_pkg::result_t                 res_q;
	logic                              out_valid_q;
	ctsu_pkg::result_t                 out_q;

	// slot table
	ctsu_pkg::slot_t                   mem_q [ctsu_pkg::MAX_TASKS];
	ctsu_pkg::slot_t                   rd_q;
	logic                              rd_en;
	logic [ctsu_pkg::SLOT_W-1:0]       rd_addr;
	logic                              wr_en;
	logic [ctsu_pkg::SLOT_W-1:0]       wr_addr;
	ctsu_pkg::slot_t                   wr_data;

	// shared adder
	alu_op_t                           alu_op;
	logic [ctsu_pkg::TICK_W-1:0]       alu_a;
	logic [ctsu_pkg::TICK_W-1:0]       alu_b;
	logic                              alu_cin;
	logic [ctsu_pkg::TICK_W:0]         alu_sum;
	logic                              due;
	logic [ctsu_pkg::CNT_W-1:0]        shift_nxt;
	logic                              out_free;
	logic                              in_xfer;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign shift_nxt = shift_q + 1'b1;

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign run_handler = out_q.handler;
	assign last        = out_q.last;

	// Operand select: tick + 1, tick - deadline (carry = tick >= deadline),
	// deadline + period.
	always_comb begin
		case (state_q)
			ST_DECODE: alu_op = OP_INC;
			ST_CMP:    alu_op = OP_GE;
			default:   alu_op = OP_ADV;
		endcase
		case (alu_op)
			OP_INC: begin
				alu_a   = tick_q;
				alu_b   = '0;
				alu_cin = 1'b1;
			end
			OP_GE: begin
				alu_a   = tick_q;
				alu_b   = ~rd_q.deadline;
				alu_cin = 1'b1;
			end
			default: begin
				alu_a   = rd_q.deadline;
				alu_b   = rd_q.period;
				alu_cin = 1'b0;
			end
		endcase
		alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {{ctsu_pkg::TICK_W{1'b0}}, alu_cin};
		due     = alu_sum[ctsu_pkg::TICK_W];
	end

	// Table port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = walk_q[ctsu_pkg::SLOT_W-1:0];
		wr_en   = 1'b0;
		wr_addr = walk_q[ctsu_pkg::SLOT_W-1:0];
		wr_data = rd_q;
		case (state_q)
			ST_DECODE: begin
				wr_addr = total_q[ctsu_pkg::SLOT_W-1:0];
				wr_data = '{handler: tag_q, deadline: delay_q, period: period_q};
				wr_en   = (mode_q == ctsu_pkg::MODE_ADD) &&
					(32'(total_q) < ctsu_pkg::MAX_TASKS);
			end
			ST_READ: begin
				rd_en = (walk_q < total_q);
			end
			ST_UPDATE: begin
				wr_data.deadline = alu_sum[ctsu_pkg::TICK_W-1:0];
				wr_en            = (rd_q.period != '0);
			end
			ST_SHIFT_RD: begin
				rd_addr = shift_nxt[ctsu_pkg::SLOT_W-1:0];
				rd_en   = (shift_nxt < total_q);
			end
			ST_SHIFT_WR: begin
				wr_addr = shift_q[ctsu_pkg::SLOT_W-1:0];
				wr_en   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in the emit state a taken result is replaced by the new one below
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						mode_q   <= mode;
						tag_q    <= handler_tag;
						delay_q  <= delay_ticks;
						period_q <= period_ticks;
						idx_q    <= slot_index;
						state_q  <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					case (mode_q)
						ctsu_pkg::MODE_TICK: begin
							tick_q  <= alu_sum[ctsu_pkg::TICK_W-1:0];
							res_q   <= '{kind: ctsu_pkg::KIND_DONE, handler: '0, last: 1'b1};
							state_q <= ST_EMIT;
						end
						ctsu_pkg::MODE_DISPATCH: begin
							walk_q  <= '0;
							state_q <= ST_READ;
						end
						ctsu_pkg::MODE_ADD: begin
							state_q <= ST_EMIT;
							if (32'(total_q) < ctsu_pkg::MAX_TASKS) begin
								total_q <= total_q + 1'b1;
								res_q   <= '{kind: ctsu_pkg::KIND_DONE, handler: '0,
									last: 1'b1};
							end else begin
								res_q   <= '{kind: ctsu_pkg::KIND_REJECT, handler: '0,
									last: 1'b1};
							end
						end
						ctsu_pkg::MODE_DELETE: begin
							if (32'(idx_q) < 32'(total_q)) begin
								shift_q <= ctsu_pkg::CNT_W'(idx_q);
								state_q <= ST_SHIFT_RD;
							end else begin
								res_q   <= '{kind: ctsu_pkg::KIND_REJECT, handler: '0,
									last: 1'b1};
								state_q <= ST_EMIT;
							end
						end
						ctsu_pkg::MODE_CLEAR: begin
							tick_q  <= '0;
							total_q <= '0;
							res_q   <= '{kind: ctsu_pkg::KIND_DONE, handler: '0, last: 1'b1};
							state_q <= ST_EMIT;
						end
						default: begin
							res_q   <= '{kind: ctsu_pkg::KIND_DONE, handler: '0, last: 1'b1};
							state_q <= ST_EMIT;
						end
					endcase
				end
				ST_READ: begin
					if (walk_q < total_q) begin
						state_q <= ST_CMP;
					end else begin
						res_q   <= '{kind: ctsu_pkg::KIND_DONE, handler: '0, last: 1'b1};
						state_q <= ST_EMIT;
					end
				end
				ST_CMP: begin
					if (due) begin
						res_q   <= '{kind: ctsu_pkg::KIND_RUN, handler: rd_q.handler,
							last: 1'b0};
						state_q <= ST_EMIT;
					end else begin
						walk_q  <= walk_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= res_q.last ? ST_IDLE : ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					// periodic: deadline advanced by the write port; one-shot: compact
					if (rd_q.period != '0) begin
						walk_q  <= walk_q + 1'b1;
						state_q <= ST_READ;
					end else begin
						shift_q <= walk_q;
						state_q <= ST_SHIFT_RD;
					end
				end
				ST_SHIFT_RD: begin
					if (shift_nxt < total_q) begin
						state_q <= ST_SHIFT_WR;
					end else begin
						total_q <= total_q - 1'b1;
						if (mode_q == ctsu_pkg::MODE_DISPATCH) begin
							// the slot moved into place is examined next
							state_q <= ST_READ;
						end else begin
							res_q   <= '{kind: ctsu_pkg::KIND_DONE, handler: '0,
								last: 1'b1};
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SHIFT_WR: begin
					shift_q <= shift_nxt;
					state_q <= ST_SHIFT_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Table never overfills.
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) <= ctsu_pkg::MAX_TASKS)
		else $error("slot count above table size");

	// The walk never points past the live slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP || state_q == ST_UPDATE) |-> (walk_q < total_q))
		else $error("walk index beyond live slots");

	// Compaction stays inside the live slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT_RD || state_q == ST_SHIFT_WR) |-> (shift_q < total_q))
		else $error("compaction index beyond live slots");

	// Loading a final result frees the block for the next item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free && res_q.last) |=> in_ready)
		else $error("block not ready after final result");

endmodule

/* dv/cooperative_task_scheduler_unit_tb.sv */
// Self-checking testbench for the cooperative task scheduler unit.
`timescale 1ns / 1ps

module cooperative_task_scheduler_unit_tb;

	// One item as offered on the input channel.
	typedef struct {
		logic [ctsu_pkg::MODE_W-1:0] mode;
		logic [ctsu_pkg::TAG_W-1:0]  tag;
		logic [ctsu_pkg::TICK_W-1:0] delay;
		logic [ctsu_pkg::TICK_W-1:0] period;
		logic [ctsu_pkg::IDX_W-1:0]  idx;
	} sched_item_t;

	// Modes the block must answer as no-ops.
	localparam logic [ctsu_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd5;
	localparam logic [ctsu_pkg::MODE_W-1:0] MODE_SPARE_C = 3'd7;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 5;
	// Longest legal quiet stretch is the long receiver hold plus one full
	// dispatch walk; this is many times that.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int TAIL_CYCLES    = 120;
	localparam int BURST_LEN      = 8;
	localparam int MAX_REPORTS    = 10;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          in_valid     = 1'b0;
	logic                          in_ready;
	logic [ctsu_pkg::MODE_W-1:0]   mode         = '0;
	logic [ctsu_pkg::TAG_W-1:0]    handler_tag  = '0;
	logic [ctsu_pkg::TICK_W-1:0]   delay_ticks  = '0;
	logic [ctsu_pkg::TICK_W-1:0]   period_ticks = '0;
	logic [ctsu_pkg::IDX_W-1:0]    slot_index   = '0;
	logic                          out_valid;
	logic                          out_ready    = 1'b0;
	logic [ctsu_pkg::KIND_W-1:0]   kind;
	logic [ctsu_pkg::TAG_W-1:0]    run_handler;
	logic                          last;

	cooperative_task_scheduler_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.handler_tag  (handler_tag),
		.delay_ticks  (delay_ticks),
		.period_ticks (period_ticks),
		.slot_index   (slot_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.run_handler  (run_handler),
		.last         (last)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Items waiting to go out, and results the block still owes us.
	sched_item_t           pending_items[$];
	ctsu_pkg::result_t     owed_results[$];

	// Our own copy of the scheduler: tick counter and compacted slot table.
	logic [ctsu_pkg::TICK_W-1:0] tbl_tick;
	ctsu_pkg::slot_t             tbl_slot[$];

	// Idle rates in percent, set per phase by the stimulus thread.
	int unsigned send_idle_pct = 30;
	int unsigned recv_idle_pct = 53;

	// Long receiver hold: stimulus bumps stall_asks, the monitor counts it out.
	int unsigned stall_asks = 0;
	int unsigned stall_taken = 0;
	int unsigned hold_left = 0;

	int unsigned       fail_count = 0;
	int unsigned       quiet_cycles = 0;
	sched_item_t       cur_item;
	ctsu_pkg::result_t head_result;

	// ---------------------------------------------------------------------
	// Expected-result bookkeeping
	// ---------------------------------------------------------------------

	task automatic owe(logic [ctsu_pkg::KIND_W-1:0] k, logic [ctsu_pkg::TAG_W-1:0] h,
		logic l);
		ctsu_pkg::result_t r;
		r.kind    = k;
		r.handler = h;
		r.last    = l;
		owed_results.push_back(r);
	endtask

	// Advance our copy of the scheduler by one accepted item and queue
	// every result that item must produce.
	task automatic step_schedule(input sched_item_t it);
		int              i;
		ctsu_pkg::slot_t s;
		case (it.mode)
			ctsu_pkg::MODE_TICK: begin
				tbl_tick = tbl_tick + 1'b1;
				owe(ctsu_pkg::KIND_DONE, '0, 1'b1);
			end
			ctsu_pkg::MODE_DISPATCH: begin
				i = 0;
				while (i < tbl_slot.size()) begin
					s = tbl_slot[i];
					if (s.deadline <= tbl_tick) begin
						owe(ctsu_pkg::KIND_RUN, s.handler, 1'b0);
						if (s.period != '0) begin
							// deadline wraps modulo 2^32
							s.deadline  = s.deadline + s.period;
							tbl_slot[i] = s;
							i++;
						end else begin
							// one-shot: the next slot slides into i and is examined too
							tbl_slot.delete(i);
						end
					end else begin
						i++;
					end
				end
				owe(ctsu_pkg::KIND_DONE, '0, 1'b1);
			end
			ctsu_pkg::MODE_ADD: begin
				if (tbl_slot.size() < ctsu_pkg::MAX_TASKS) begin
					s.handler  = it.tag;
					s.deadline = it.delay;
					s.period   = it.period;
					tbl_slot.push_back(s);
					owe(ctsu_pkg::KIND_DONE, '0, 1'b1);
				end else begin
					owe(ctsu_pkg::KIND_REJECT, '0, 1'b1);
				end
			end
			ctsu_pkg::MODE_DELETE: begin
				if (int'(it.idx) < tbl_slot.size()) begin
					tbl_slot.delete(int'(it.idx));
					owe(ctsu_pkg::KIND_DONE, '0, 1'b1);
				end else begin
					owe(ctsu_pkg::KIND_REJECT, '0, 1'b1);
				end
			end
			ctsu_pkg::MODE_CLEAR: begin
				tbl_slot.delete();
				tbl_tick = '0;
				owe(ctsu_pkg::KIND_DONE, '0, 1'b1);
			end
			default: owe(ctsu_pkg::KIND_DONE, '0, 1'b1);
		endcase
	endtask

	// ---------------------------------------------------------------------
	// Driver: presents pending items, predicts on each accepted transfer
	// ---------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			mode         <= '0;
			handler_tag  <= '0;
			delay_ticks  <= '0;
			period_ticks <= '0;
			slot_index   <= '0;
			tbl_tick     = '0;
			tbl_slot.delete();
		end else begin
			if (in_valid && in_ready)
				step_schedule(cur_item);
			// Load the next item only when nothing is held on the channel.
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
					cur_item     = pending_items.pop_front();
					mode         <= cur_item.mode;
					handler_tag  <= cur_item.tag;
					delay_ticks  <= cur_item.delay;
					period_ticks <= cur_item.period;
					slot_index   <= cur_item.idx;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: random backpressure, long hold on request, result checks
	// ---------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("unexpected result transfer: kind=%0d handler=%02h last=%0b",
							kind, run_handler, last);
				end else begin
					head_result = owed_results.pop_front();
					if (kind !== head_result.kind || run_handler !== head_result.handler ||
						last !== head_result.last) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display({"mismatch: expected kind=%0d handler=%02h last=%0b,",
								" got kind=%0d handler=%02h last=%0b"},
								head_result.kind, head_result.handler, head_result.last,
								kind, run_handler, last);
					end
				end
			end
			if (stall_asks != stall_taken) begin
				stall_taken = stall_asks;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: too long with no transfer on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------

	task automatic queue_item(logic [ctsu_pkg::MODE_W-1:0] m, logic [ctsu_pkg::TAG_W-1:0] t,
		logic [ctsu_pkg::TICK_W-1:0] d, logic [ctsu_pkg::TICK_W-1:0] p,
		logic [ctsu_pkg::IDX_W-1:0] x);
		sched_item_t it;
		it.mode   = m;
		it.tag    = t;
		it.delay  = d;
		it.period = p;
		it.idx    = x;
		pending_items.push_back(it);
	endtask

	// An add whose deadline lands near the current count so that it
	// actually comes due; now and then a far deadline or a huge period.
	function automatic sched_item_t make_add();
		sched_item_t it;
		it.mode   = ctsu_pkg::MODE_ADD;
		it.tag    = ctsu_pkg::TAG_W'($urandom());
		it.delay  = $urandom();
		it.period = $urandom();
		it.idx    = ctsu_pkg::IDX_W'($urandom());
		if ($urandom_range(0, 4) != 0)
			it.delay = tbl_tick + $urandom_range(0, 6);
		case ($urandom_range(0, 4))
			0, 1: it.period = '0;
			2, 3: it.period = $urandom_range(1, 5);
			default: ;
		endcase
		return it;
	endfunction

	task automatic queue_random_item();
		sched_item_t it;
		int unsigned pick;
		it.tag    = ctsu_pkg::TAG_W'($urandom());
		it.delay  = $urandom();
		it.period = $urandom();
		it.idx    = ctsu_pkg::IDX_W'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 24) begin
			it.mode = ctsu_pkg::MODE_TICK;
		end else if (pick < 50) begin
			it.mode = ctsu_pkg::MODE_DISPATCH;
		end else if (pick < 78) begin
			it = make_add();
		end else if (pick < 93) begin
			it.mode = ctsu_pkg::MODE_DELETE;
			// mostly a live slot; otherwise whatever index comes up
			if (tbl_slot.size() != 0 && $urandom_range(0, 3) != 0)
				it.idx = ctsu_pkg::IDX_W'($urandom_range(0, tbl_slot.size() - 1));
		end else if (pick < 96) begin
			it.mode = ctsu_pkg::MODE_CLEAR;
		end else begin
			it.mode = ctsu_pkg::MODE_W'($urandom_range(32'(MODE_SPARE_A),
				32'(MODE_SPARE_C)));
		end
		pending_items.push_back(it);
	endtask

	// Block until every queued item has been transferred, so that our
	// copy of the table is current when the next burst is shaped.
	task automatic wait_taken();
		while (pending_items.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	task automatic run_random(int unsigned n_items);
		int unsigned made;
		int          k;
		made = 0;
		while (made < n_items) begin
			if ($urandom_range(0, 11) == 0) begin
				// fill to the brim, one add past full, then walk it
				for (k = tbl_slot.size(); k <= ctsu_pkg::MAX_TASKS; k++) begin
					pending_items.push_back(make_add());
					made++;
				end
				queue_item(ctsu_pkg::MODE_DISPATCH, ctsu_pkg::TAG_W'($urandom()),
					$urandom(), $urandom(), ctsu_pkg::IDX_W'($urandom()));
				made++;
			end else begin
				for (k = 0; k < BURST_LEN; k++) begin
					queue_random_item();
					made++;
				end
			end
			wait_taken();
		end
	endtask

	initial begin
		int unsigned k;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Phase 1: sender idles 30%, receiver 53%.
		send_idle_pct = 30;
		recv_idle_pct = 53;

		// Directed: empty table, bad delete, spare modes.
		queue_item(ctsu_pkg::MODE_TICK, '0, '0, '0, '0);
		queue_item(ctsu_pkg::MODE_DISPATCH, '0, '0, '0, '0);
		queue_item(ctsu_pkg::MODE_DELETE, '0, '0, '0, '0);
		queue_item(MODE_SPARE_C, 8'hFF, '1, '1, '1);
		queue_item(MODE_SPARE_A, '0, '0, '0, '0);
		// Two due one-shots back to back: the second slides into the freed
		// slot and must still run in the same walk.
		queue_item(ctsu_pkg::MODE_ADD, 8'hFF, 32'd0, 32'd0, '0);
		queue_item(ctsu_pkg::MODE_ADD, 8'h01, 32'd1, 32'd0, '0);
		// Due periodic slot whose next deadline wraps past 2^32 to zero.
		queue_item(ctsu_pkg::MODE_ADD, 8'h00, 32'd1, 32'hFFFF_FFFF, '0);
		// Never due.
		queue_item(ctsu_pkg::MODE_ADD, 8'h80, 32'hFFFF_FFFF, 32'd0, '0);
		queue_item(ctsu_pkg::MODE_ADD, 8'h7F, 32'd0, 32'd1, '0);
		for (k = 1; k <= 11; k++)
			queue_item(ctsu_pkg::MODE_ADD, ctsu_pkg::TAG_W'(32'h10 + k), k % 3, k, '0);
		// Table now full: this one is turned away.
		queue_item(ctsu_pkg::MODE_ADD, 8'h55, 32'd0, 32'd0, '0);
		queue_item(ctsu_pkg::MODE_DISPATCH, '0, '0, '0, '0);
		// Wrapped slot sits below the count and runs again.
		queue_item(ctsu_pkg::MODE_DISPATCH, '0, '0, '0, '0);
		queue_item(ctsu_pkg::MODE_DELETE, '0, '0, '0, 4'd15);
		queue_item(ctsu_pkg::MODE_DELETE, '0, '0, '0, 4'd13);
		queue_item(ctsu_pkg::MODE_DELETE, '0, '0, '0, 4'd0);
		queue_item(ctsu_pkg::MODE_CLEAR, '0, '0, '0, '0);
		wait_taken();

		run_random(94);

		// Phase 2: roles swapped.
		send_idle_pct = 53;
		recv_idle_pct = 30;
		run_random(94);

		// Phase 3: no idling, with one long receiver hold while items keep
		// coming so the block backs up and stalls its input.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(40);
		stall_asks++;
		run_random(54);

		while (owed_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (fail_count == 0 && owed_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
